### rtl/keyframe_texture_flip_lookup_top_defines.svh
// Assertion macros for the keyframe texture lookup block
`ifndef KEYFRAME_TEXTURE_FLIP_LOOKUP_TOP_DEFINES_SVH
`define KEYFRAME_TEXTURE_FLIP_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KFT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kft check failed");

// next-cycle implication
`define KFT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kft check failed");

`endif

### rtl/kft_pkg.sv
// Types and constants shared by the keyframe texture lookup block
package kft_pkg;

  localparam int CMD_W      = 2;
  localparam int ENTRY_W    = 6;
  localparam int POS_W      = 32;
  localparam int VAL_W      = 16;
  localparam int TEX_W      = 16;
  localparam int SLOT_W     = 4;
  localparam int KCNT_W     = 5;
  localparam int TCNT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int RATIO_W    = 17;
  localparam int FRAME_W    = 8;
  localparam int ACC_W      = VAL_W + RATIO_W;
  localparam int DIV_STEPS  = RATIO_W;
  localparam int DCNT_W     = 5;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEX  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_SLOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_COUNT = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_LOOK,
    S_TEX,
    S_DONE
  } kft_state_t;

endpackage

### rtl/kft_div.sv
// Bit-serial restoring divider for the Q1.16 segment ratio
module kft_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kft_pkg::POS_W-1:0]   dividend,
  input  logic [kft_pkg::POS_W-1:0]   divisor,
  output logic                        done,
  output logic [kft_pkg::RATIO_W-1:0] quotient
);
  import kft_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]   den_r, den_nxt;
  logic [RATIO_W-1:0] q_r, q_nxt;
  logic [POS_W:0]     diff;
  logic               ge;

  // the caller keeps dividend <= divisor, so the quotient never exceeds one in Q1.16
  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = rem_r - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, dividend};
      den_nxt  = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[RATIO_W-2:0], ge};
      rem_nxt = ge ? {diff[POS_W-1:0], 1'b0} : {rem_r[POS_W-1:0], 1'b0};
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/keyframe_texture_flip_lookup_top.sv
// Keyframe interpolation with texture-id lookup, top level
// Load commands are accepted back to back while no evaluate is in progress.
// An evaluate reads one key per search step and takes its segment ratio from the
// serial ratio divider; its result is held back by output stalls.
// One request at a time; the next is taken in the cycle after the result is loaded.
// Reset clears the configuration registers and control; the tables are not cleared.
`include "keyframe_texture_flip_lookup_top_defines.svh"

module keyframe_texture_flip_lookup_top #(
  parameter int MAX_KEYS     = 16,
  parameter int MAX_TEXTURES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kft_pkg::CMD_W-1:0]      in_command,
  input  logic [kft_pkg::ENTRY_W-1:0]    in_entry_index,
  input  logic [kft_pkg::POS_W-1:0]      in_key_position,
  input  logic [kft_pkg::VAL_W-1:0]      in_key_value,
  input  logic [kft_pkg::TEX_W-1:0]      in_texture_id,
  input  logic [kft_pkg::POS_W-1:0]      in_track_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kft_pkg::SLOT_W-1:0]     out_slot,
  output logic [kft_pkg::TEX_W-1:0]      out_chosen_texture,
  output logic                           out_held_last,
  output logic                           out_lookup_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kft_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kft_pkg::*;

  localparam int KW    = $clog2(MAX_KEYS);
  localparam int KN_W  = ($clog2(MAX_KEYS + 1) > KCNT_W) ? $clog2(MAX_KEYS + 1) : KCNT_W;
  localparam int TW    = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
  localparam int TC_W  = ($clog2(MAX_TEXTURES + 1) > FRAME_W) ?
                         $clog2(MAX_TEXTURES + 1) : FRAME_W;

  // configuration
  logic [SLOT_W-1:0]  slot_r;
  logic [KCNT_W-1:0]  key_count_r;
  logic [TCNT_W-1:0]  tex_count_r;
  logic [KN_W-1:0]    n_keys;
  logic [TC_W-1:0]    tc_cnt;

  // memories
  key_t               key_mem [MAX_KEYS];
  logic [TEX_W-1:0]   tex_mem [MAX_TEXTURES];
  key_t               key_rd_r;
  logic [TEX_W-1:0]   tex_rd_r;
  logic [KW-1:0]      key_raddr;
  logic [TW-1:0]      tex_raddr;
  logic               key_we, tex_we;

  // evaluation
  kft_state_t         state_r, state_nxt;
  logic               in_accept;
  logic [POS_W-1:0]   t_r, t_nxt;
  logic [KW-1:0]      j_r, j_nxt;
  key_t               left_r, left_nxt;
  logic [VAL_W-1:0]   right_val_r, right_val_nxt;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               held_r, held_nxt;
  logic               err_r, err_nxt;
  logic [TEX_W-1:0]   tex_r, tex_nxt;
  logic               held_cond, advance, seg_div, tex_hit;
  logic [VAL_W-1:0]   mul_a;
  logic [RATIO_W-1:0] mul_b;
  logic [ACC_W-1:0]   prod;
  logic [ACC_W-1:0]   v_sum;
  logic               div_start, div_done;
  logic [RATIO_W-1:0] div_quot;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [TEX_W-1:0]   out_tex_r;
  logic               out_held_r, out_err_r;
  logic               out_free, out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign n_keys = (KN_W'(key_count_r) > KN_W'(MAX_KEYS)) ? KN_W'(MAX_KEYS) : KN_W'(key_count_r);
  assign tc_cnt = (TC_W'(tex_count_r) > TC_W'(MAX_TEXTURES)) ?
                  TC_W'(MAX_TEXTURES) : TC_W'(tex_count_r);

  assign key_we = in_accept && (in_command == CMD_KEY) &&
                  (32'(in_entry_index) < 32'(MAX_KEYS));
  assign tex_we = in_accept && (in_command == CMD_TEX) &&
                  (32'(in_entry_index) < 32'(MAX_TEXTURES));

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[KW'(in_entry_index)] <= '{pos: in_key_position, val: in_key_value};
    end
    key_rd_r <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (tex_we) begin
      tex_mem[TW'(in_entry_index)] <= in_texture_id;
    end
    tex_rd_r <= tex_mem[tex_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      key_count_r <= '0;
      tex_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXTURE_SLOT:  slot_r      <= cfg_data[SLOT_W-1:0];
        CFG_KEY_COUNT:     key_count_r <= cfg_data[KCNT_W-1:0];
        CFG_TEXTURE_COUNT: tex_count_r <= cfg_data[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign held_cond = (n_keys == KN_W'(1)) || (t_r > key_rd_r.pos);
  assign advance   = (KN_W'(j_r) < (n_keys - KN_W'(1))) && (key_rd_r.pos < t_r);
  assign seg_div   = (key_rd_r.pos > left_r.pos) && (t_r > left_r.pos);
  assign tex_hit   = TC_W'(frame_r) < tc_cnt;
  assign out_free  = !out_valid_r || !out_stall;

  // one multiplier, shared by both interpolation terms
  assign mul_a = (state_r == S_MUL1) ? left_r.val : right_val_r;
  assign mul_b = (state_r == S_MUL1) ? (RATIO_ONE - ratio_r) : ratio_r;
  assign prod  = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign v_sum = acc_r + prod;

  kft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t_r - left_r.pos),
    .divisor  (key_rd_r.pos - left_r.pos),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_command == CMD_EVAL) begin
          state_nxt = (n_keys == '0) ? S_DONE : S_LAST;
        end
      end
      S_LAST:  state_nxt = held_cond ? S_LOOK : S_FIRST;
      S_FIRST: state_nxt = S_SCAN;
      S_SCAN: begin
        if (!advance) begin
          state_nxt = seg_div ? S_DIV : S_MUL1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_LOOK;
      S_LOOK:  state_nxt = tex_hit ? S_TEX : S_DONE;
      S_TEX:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    t_nxt         = t_r;
    j_nxt         = j_r;
    left_nxt      = left_r;
    right_val_nxt = right_val_r;
    ratio_nxt     = ratio_r;
    acc_nxt       = acc_r;
    frame_nxt     = frame_r;
    held_nxt      = held_r;
    err_nxt       = err_r;
    tex_nxt       = tex_r;
    key_raddr     = '0;
    tex_raddr     = '0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        t_nxt     = in_track_position;
        held_nxt  = 1'b0;
        err_nxt   = (n_keys == '0);
        tex_nxt   = '0;
        key_raddr = KW'(n_keys - KN_W'(1));
      end
      S_LAST: begin
        if (held_cond) begin
          held_nxt  = 1'b1;
          frame_nxt = key_rd_r.val[VAL_W-1:VAL_W-FRAME_W];
        end
      end
      S_FIRST: begin
        left_nxt  = key_rd_r;
        j_nxt     = KW'(1);
        key_raddr = KW'(1);
      end
      S_SCAN: begin
        if (advance) begin
          left_nxt  = key_rd_r;
          j_nxt     = j_r + KW'(1);
          key_raddr = j_r + KW'(1);
        end else begin
          right_val_nxt = key_rd_r.val;
          ratio_nxt     = '0;
          div_start     = seg_div;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ratio_nxt = div_quot;
        end
      end
      S_MUL1: acc_nxt = prod;
      S_MUL2: frame_nxt = v_sum[2*VAL_W-1:2*VAL_W-FRAME_W];
      S_LOOK: begin
        tex_raddr = TW'(frame_r);
        if (!tex_hit) begin
          err_nxt = 1'b1;
        end
      end
      S_TEX:  tex_nxt = tex_rd_r;
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r         <= t_nxt;
    j_r         <= j_nxt;
    left_r      <= left_nxt;
    right_val_r <= right_val_nxt;
    ratio_r     <= ratio_nxt;
    acc_r       <= acc_nxt;
    frame_r     <= frame_nxt;
    held_r      <= held_nxt;
    err_r       <= err_nxt;
    tex_r       <= tex_nxt;
    if (out_load) begin
      out_slot_r <= slot_r;
      out_tex_r  <= tex_r;
      out_held_r <= held_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_chosen_texture = out_tex_r;
  assign out_held_last      = out_held_r;
  assign out_lookup_error   = out_err_r;

  `KFT_ASSERT_IMP(a_div_done_in_div, div_done, state_r == S_DIV)
  `KFT_ASSERT_IMP(a_err_zero_tex, out_valid_r && out_err_r, out_tex_r == '0)
  `KFT_ASSERT_NXT(a_done_waits, state_r == S_DONE && out_valid_r && out_stall,
                  state_r == S_DONE)

endmodule

### bench/tb_keyframe_texture_flip_lookup_top.sv
// Self-checking testbench for the keyframe texture lookup block
module tb_keyframe_texture_flip_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kft_pkg::*;

  localparam int MAX_KEYS     = 16;
  localparam int MAX_TEXTURES = 64;
  localparam int DRAIN_CYCLES = 64;   // covers the longest evaluate plus load slack
  localparam int PHASES       = 24;
  localparam int BODY_ITEMS   = 28;
  localparam int NPLAN        = 29;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]   key_pos;
    logic [VAL_W-1:0]   key_val;
    logic [TEX_W-1:0]   tex_id;
    logic [POS_W-1:0]   track;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TEX_W-1:0]  texture;
    logic              held;
    logic              err;
  } lookup_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    request_t              rq;
    logic                  fixed;
    lookup_t               want;
  } plan_row_t;

  localparam request_t NO_REQ  = '0;
  localparam lookup_t  NO_WANT = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_command;
  logic [ENTRY_W-1:0] in_entry_index;
  logic [POS_W-1:0] in_key_position;
  logic [VAL_W-1:0] in_key_value;
  logic [TEX_W-1:0] in_texture_id;
  logic [POS_W-1:0] in_track_position;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic [TEX_W-1:0] out_chosen_texture;
  logic out_held_last;
  logic out_lookup_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  bit [POS_W-1:0]  pos_mem [MAX_KEYS];
  bit [VAL_W-1:0]  val_mem [MAX_KEYS];
  bit [TEX_W-1:0]  tex_mem [MAX_TEXTURES];
  bit [SLOT_W-1:0] reg_slot = '0;
  bit [KCNT_W-1:0] reg_keys = '0;
  bit [TCNT_W-1:0] reg_texs = '0;

  lookup_t   lookups_due[$];
  plan_row_t plan [NPLAN];
  int        errors = 0;
  int        results_seen = 0;
  bit        calm = 1'b1;

  always #4 clk = ~clk;

  keyframe_texture_flip_lookup_top #(
    .MAX_KEYS     (MAX_KEYS),
    .MAX_TEXTURES (MAX_TEXTURES)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_entry_index     (in_entry_index),
    .in_key_position    (in_key_position),
    .in_key_value       (in_key_value),
    .in_texture_id      (in_texture_id),
    .in_track_position  (in_track_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot           (out_slot),
    .out_chosen_texture (out_chosen_texture),
    .out_held_last      (out_held_last),
    .out_lookup_error   (out_lookup_error),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  task automatic report_mismatch(string what);
    if (errors < 40) $display("MISMATCH result %0d at %0t: %s", results_seen, $time, what);
    errors++;
  endtask

  function automatic lookup_t eval_track(logic [POS_W-1:0] track);
    lookup_t res;
    int unsigned n, tc, seg;
    logic [POS_W-1:0] p_lo, p_hi;
    logic [63:0] ratio, mix, frame;
    res = '0;
    res.slot = reg_slot;
    n = (reg_keys > MAX_KEYS) ? MAX_KEYS : reg_keys;
    tc = (reg_texs > MAX_TEXTURES) ? MAX_TEXTURES : reg_texs;
    if (n == 0) begin
      res.err = 1'b1;
      return res;
    end
    if (n == 1 || track > pos_mem[n - 1]) begin
      res.held = 1'b1;
      frame = val_mem[n - 1] >> 8;
    end else begin
      seg = 0;
      while (seg + 1 < n - 1 && pos_mem[seg + 1] < track) seg++;
      p_lo = pos_mem[seg];
      p_hi = pos_mem[seg + 1];
      ratio = '0;
      // zero or negative span and positions at or before the left key give ratio 0
      if (p_hi > p_lo && track > p_lo) begin
        ratio = {16'd0, track - p_lo, 16'd0} / {32'd0, p_hi - p_lo};
        if (ratio > 64'd65536) ratio = 64'd65536;
      end
      mix = val_mem[seg] * (64'd65536 - ratio) + val_mem[seg + 1] * ratio;
      frame = mix >> 24;
    end
    if (frame < tc) res.texture = tex_mem[frame];
    else res.err = 1'b1;
    return res;
  endfunction

  function automatic bit apply_request(request_t rq, output lookup_t res);
    res = '0;
    case (rq.cmd)
      CMD_KEY: begin
        if (rq.entry < MAX_KEYS) begin
          pos_mem[rq.entry] = rq.key_pos;
          val_mem[rq.entry] = rq.key_val;
        end
      end
      CMD_TEX: begin
        if (rq.entry < MAX_TEXTURES) tex_mem[rq.entry] = rq.tex_id;
      end
      CMD_EVAL: begin
        res = eval_track(rq.track);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic request_t noise_request();
    request_t rq;
    rq.cmd     = CMD_W'($urandom);
    rq.entry   = ENTRY_W'($urandom);
    rq.key_pos = $urandom;
    rq.key_val = VAL_W'($urandom);
    rq.tex_id  = TEX_W'($urandom);
    rq.track   = $urandom;
    return rq;
  endfunction

  // mostly positions on, between or past the keys in use
  function automatic logic [POS_W-1:0] pick_track();
    int unsigned n, j;
    logic [POS_W-1:0] lo, hi;
    n = (reg_keys > MAX_KEYS) ? MAX_KEYS : reg_keys;
    if (n == 0) return $urandom;
    j = $urandom_range(0, n - 1);
    lo = pos_mem[j];
    hi = pos_mem[n - 1];
    case ($urandom_range(0, 9))
      0, 1, 2: return lo;
      3, 4, 5, 6: begin
        if (j + 1 < n && pos_mem[j + 1] > lo) return lo + $urandom_range(0, pos_mem[j + 1] - lo);
        return lo + $urandom_range(0, 255);
      end
      7: begin
        if (hi != '1) return hi + $urandom_range(1, 32'hFFFF_FFFF - hi);
      end
      default: ;
    endcase
    return $urandom;
  endfunction

  task automatic send(request_t rq, bit use_want, lookup_t want);
    int unsigned gap;
    bit took;
    lookup_t res;
    gap = 0;
    while (!calm && $urandom_range(99) < 23) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= rq.cmd;
    in_entry_index    <= rq.entry;
    in_key_position   <= rq.key_pos;
    in_key_value      <= rq.key_val;
    in_texture_id     <= rq.tex_id;
    in_track_position <= rq.track;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (apply_request(rq, res)) lookups_due.insert(lookups_due.size(), use_want ? want : res);
  endtask

  // wait until every result is back and loads have had time to land
  task automatic settle();
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit took;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEXTURE_SLOT:  reg_slot = data[SLOT_W-1:0];
      CFG_KEY_COUNT:     reg_keys = data[KCNT_W-1:0];
      CFG_TEXTURE_COUNT: reg_texs = data[TCNT_W-1:0];
      default: ;
    endcase
  endtask

  // full key table: mostly ascending, some with repeated positions, some unordered
  task automatic load_keyset();
    request_t rq;
    logic [POS_W-1:0] at, step_max;
    int unsigned shape, te, vmax;
    shape = $urandom_range(0, 9);
    at = $urandom_range(0, 32'h00FF_FFFF);
    if (shape == 9) at = at + 32'hF000_0000;
    step_max = 32'd1 << $urandom_range(4, (shape == 9) ? 22 : 26);
    te = (reg_texs > MAX_TEXTURES) ? MAX_TEXTURES : reg_texs;
    vmax = (te + 2) * 256 - 1;
    for (int k = 0; k < MAX_KEYS; k++) begin
      rq = noise_request();
      rq.cmd = CMD_KEY;
      rq.entry = ENTRY_W'(k);
      if (shape == 8) begin
        rq.key_pos = $urandom;
      end else begin
        rq.key_pos = at;
        if (shape < 6 || shape > 7 || $urandom_range(0, 3) != 0)
          at = at + $urandom_range(1, step_max);
      end
      if ($urandom_range(0, 4) != 0) rq.key_val = VAL_W'($urandom_range(0, vmax));
      send(rq, 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 23);

  always @(negedge clk) begin : result_check
    lookup_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (lookups_due.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = lookups_due.pop_front();
        if (out_slot !== want.slot)
          report_mismatch($sformatf("slot got %0d want %0d", out_slot, want.slot));
        if (out_chosen_texture !== want.texture)
          report_mismatch($sformatf("texture got %h want %h", out_chosen_texture, want.texture));
        if (out_held_last !== want.held)
          report_mismatch($sformatf("held got %b want %b", out_held_last, want.held));
        if (out_lookup_error !== want.err)
          report_mismatch($sformatf("error got %b want %b", out_lookup_error, want.err));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_keyframe_texture_flip_lookup_top NOT OK");
    $finish;
  end

  initial begin
    request_t rq;
    int made, pick;
    logic [CFG_DATA_W-1:0] slot_v, keys_v, texs_v;

    plan = '{
      // no keys right after reset
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF}, 1'b1, '{4'd0, 16'd0, 1'b0, 1'b1}},
      '{ROW_REG, CFG_TEXTURE_SLOT, 7'd15, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REG, CFG_KEY_COUNT, 7'd1, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REG, CFG_TEXTURE_COUNT, 7'd64, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd0, 32'd0, 16'h3F80, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_TEX, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
      // single key: hold its frame 63 and hit the last texture entry
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b1, '{4'd15, 16'hFFFF, 1'b1, 1'b0}},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd0}, 1'b0, NO_WANT},
      // frame 255 is past the texture count
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF}, 1'b1, '{4'd15, 16'd0, 1'b1, 1'b1}},
      // key writes beyond the table are dropped, spare command is a no-op
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd63, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd16, 32'h1234_5678, 16'h0100, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_SPARE, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b1, '{4'd15, 16'd0, 1'b1, 1'b1}},
      // counts above the table sizes saturate
      '{ROW_REG, CFG_KEY_COUNT, 7'd31, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REG, CFG_TEXTURE_COUNT, 7'd127, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd15, 32'hFFFF_FFFF, 16'h0100, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
      // two keys at one position: zero span
      '{ROW_REG, CFG_KEY_COUNT, 7'd2, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd0, 32'h0001_0000, 16'h0500, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd1, 32'h0001_0000, 16'h2A00, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'h0001_0000}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b0, NO_WANT},
      // proper segment: midpoint, right end, just past the end
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_KEY, 6'd1, 32'h0003_0000, 16'h2A00, 16'd0, 32'd0}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'h0002_0000}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'h0003_0000}, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'h0003_0001}, 1'b0, NO_WANT},
      // empty texture table: every lookup fails
      '{ROW_REG, CFG_TEXTURE_COUNT, 7'd0, NO_REQ, 1'b0, NO_WANT},
      '{ROW_REQ, CFG_TEXTURE_SLOT, 7'd0,
        '{CMD_EVAL, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b1, '{4'd15, 16'd0, 1'b0, 1'b1}}
    };

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_command        <= CMD_KEY;
    in_entry_index    <= '0;
    in_key_position   <= '0;
    in_key_value      <= '0;
    in_texture_id     <= '0;
    in_track_position <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_TEXTURE_SLOT;
    cfg_data          <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tables come up undefined, so every entry is written before any lookup
    for (int k = 0; k < MAX_KEYS; k++) begin
      rq = noise_request();
      rq.cmd = CMD_KEY;
      rq.entry = ENTRY_W'(k);
      send(rq, 1'b0, NO_WANT);
    end
    for (int k = 0; k < MAX_TEXTURES; k++) begin
      rq = noise_request();
      rq.cmd = CMD_TEX;
      rq.entry = ENTRY_W'(k);
      send(rq, 1'b0, NO_WANT);
    end
    calm = 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) write_reg(plan[r].reg_idx, plan[r].reg_data);
      else send(plan[r].rq, plan[r].fixed, plan[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph >= 8 && ph < 12);
      slot_v = CFG_DATA_W'($urandom);
      keys_v = CFG_DATA_W'($urandom_range(2, MAX_KEYS));
      texs_v = CFG_DATA_W'($urandom_range(1, MAX_TEXTURES));
      case (ph)
        0: begin
          keys_v = 7'd31;
          texs_v = 7'd127;
        end
        1: keys_v = 7'd1;
        2: keys_v = 7'd0;
        3: begin
          keys_v = 7'h62;
          texs_v = 7'd0;
          slot_v = 7'd0;
        end
        4: begin
          keys_v = 7'd16;
          texs_v = 7'd64;
          slot_v = 7'd15;
        end
        default: ;
      endcase
      write_reg(CFG_TEXTURE_SLOT, slot_v);
      write_reg(CFG_KEY_COUNT, keys_v);
      write_reg(CFG_TEXTURE_COUNT, texs_v);
      load_keyset();
      repeat (8) begin
        rq = noise_request();
        rq.cmd = CMD_TEX;
        send(rq, 1'b0, NO_WANT);
      end

      made = 0;
      while (made < BODY_ITEMS) begin
        rq = noise_request();
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          rq.cmd = CMD_EVAL;
          rq.track = pick_track();
          made++;
        end else if (pick < 77) begin
          rq.cmd = CMD_KEY;
          rq.entry = ENTRY_W'($urandom_range(0, MAX_KEYS - 1));
          if (pick < 73) rq.key_pos = pos_mem[rq.entry];  // new value, same position
          made++;
        end else if (pick < 89) begin
          rq.cmd = CMD_TEX;
          made++;
        end else if (pick < 95) begin
          rq.cmd = CMD_SPARE;
        end else begin
          rq.cmd = CMD_KEY;
          rq.entry = ENTRY_W'($urandom_range(MAX_KEYS, 63));
        end
        send(rq, 1'b0, NO_WANT);
      end
    end
    calm = 1'b0;

    settle();
    if (errors == 0) $display("tb_keyframe_texture_flip_lookup_top OK");
    else $display("tb_keyframe_texture_flip_lookup_top NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/kft_pkg.sv
rtl/kft_div.sv
rtl/keyframe_texture_flip_lookup_top.sv
bench/tb_keyframe_texture_flip_lookup_top.sv
